### hdl/positional_integer_list_macros.svh
// Assertion macros for the positional integer list.
// Depends on clk_i and rst_ni in the module that includes this header.
`ifndef POSITIONAL_INTEGER_LIST_MACROS_SVH
`define POSITIONAL_INTEGER_LIST_MACROS_SVH

// check on every clock edge outside reset
`define PIL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define PIL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/pil_pkg.sv
// Shared types and constants of the positional integer list.
// No dependencies; used by every module of the block.
package pil_pkg;

  localparam int POS_W          = 5;
  localparam int POS2_W         = 4;
  localparam int VAL_W          = 32;
  localparam int CNT_OUT_W      = 5;
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_READ    = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_SWAP    = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_TAKE_LEFT  = 3'd1,
    CELL_TAKE_RIGHT = 3'd2,
    CELL_LOAD       = 3'd3,
    CELL_CLEAR      = 3'd4
  } cell_op_e;

  typedef struct packed {
    req_e                     req_type;
    logic [POS_W-1:0]         position;
    logic [POS2_W-1:0]        second_position;
    logic signed [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  read_value;
    logic [CNT_OUT_W-1:0]     count;
  } res_t;

  typedef struct packed {
    status_e status;
    req_e    kind;
    logic    ok;
  } dec_t;

endpackage

### hdl/pil_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on pil_pkg.
module pil_cell
  import pil_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_op_e              op_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_TAKE_LEFT:  data_d = left_i;
      CELL_TAKE_RIGHT: data_d = right_i;
      CELL_LOAD:       data_d = wdata_i;
      CELL_CLEAR:      data_d = '0;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### hdl/pil_decode.sv
// Request check: position range, full list and unknown types give the status.
// Depends on pil_pkg.
module pil_decode
  import pil_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int CNT_W    = $clog2(DEF_CAPACITY + 1)
) (
  input  req_t             req_i,
  input  logic [CNT_W-1:0] count_i,
  output dec_t             dec_o
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CMP_W-1:0] pos, pos2, n;
  logic             pos_lt_n, pos2_lt_n;

  assign pos       = CMP_W'(req_i.position);
  assign pos2      = CMP_W'(req_i.second_position);
  assign n         = CMP_W'(count_i);
  assign pos_lt_n  = pos < n;
  assign pos2_lt_n = pos2 < n;

  always_comb begin
    dec_o.kind   = req_i.req_type;
    dec_o.status = STATUS_RANGE;
    unique case (req_i.req_type)
      REQ_INSERT: begin
        if (pos > n) begin
          dec_o.status = STATUS_RANGE;
        end else if (n >= CMP_W'(CAPACITY)) begin
          dec_o.status = STATUS_FULL;
        end else begin
          dec_o.status = STATUS_OK;
        end
      end
      REQ_DELETE, REQ_READ, REQ_REPLACE: begin
        dec_o.status = pos_lt_n ? STATUS_OK : STATUS_RANGE;
      end
      REQ_SWAP: begin
        dec_o.status = (pos_lt_n && pos2_lt_n) ? STATUS_OK : STATUS_RANGE;
      end
      default: dec_o.status = STATUS_RANGE;
    endcase
    dec_o.ok = (dec_o.status == STATUS_OK);
  end

endmodule

### hdl/positional_integer_list.sv
// Positional integer list: a row of cells holding the entries, a request check
// and a registered result. Depends on pil_pkg, pil_cell, pil_decode and the macros.
//
//   channel | signals                          | payload
//   request | in_valid_i / in_ready_o          | in_req_i  (req_t)
//   result  | out_valid_o / out_ready_i        | out_res_o (res_t)
//
// One request per cycle while in_ready_o is high: every cell takes its next entry
// from itself, a neighbor or the write data, or is cleared, in the cycle the
// request is accepted; the result shows in the cycle after, from the output
// register. A request is accepted while the result register is empty or being
// emptied. Reset clears all cells and the count; no clearing pass is needed.
`include "positional_integer_list_macros.svh"

module positional_integer_list
  import pil_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_wdata [CAPACITY];
  cell_op_e              cell_op [CAPACITY];
  logic [CAPACITY-1:0]   hit1, hit2;
  logic [DATA_WIDTH-1:0] rd1, rd2, val_ext;
  logic [CMP_W-1:0]      pos, pos2, n;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  accept;
  logic                  is_full;
  logic                  out_valid_q;
  res_t                  out_q;
  dec_t                  dec;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign is_full    = (cnt_q == CNT_W'(CAPACITY));

  assign pos     = CMP_W'(in_req_i.position);
  assign pos2    = CMP_W'(in_req_i.second_position);
  assign n       = CMP_W'(cnt_q);
  assign val_ext = DATA_WIDTH'($unsigned(in_req_i.value));

  pil_decode #(
    .CAPACITY(CAPACITY),
    .CNT_W   (CNT_W)
  ) u_decode (
    .req_i  (in_req_i),
    .count_i(cnt_q),
    .dec_o  (dec)
  );

  always_comb begin
    rd1 = '0;
    rd2 = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd1 = rd1 | (cell_data[i] & {DATA_WIDTH{hit1[i]}});
      rd2 = rd2 | (cell_data[i] & {DATA_WIDTH{hit2[i]}});
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX  = CMP_W'(g);
    localparam logic [CMP_W-1:0] IDX1 = CMP_W'(g + 1);
    logic [DATA_WIDTH-1:0] left, right;

    assign hit1[g] = (pos == IDX);
    assign hit2[g] = (pos2 == IDX);

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    always_comb begin
      cell_op[g]    = CELL_HOLD;
      cell_wdata[g] = val_ext;
      if (accept && dec.ok) begin
        unique case (dec.kind)
          REQ_INSERT: begin
            if (hit1[g]) begin
              cell_op[g] = CELL_LOAD;
            end else if (IDX > pos && IDX <= n) begin
              cell_op[g] = CELL_TAKE_LEFT;
            end
          end
          REQ_DELETE: begin
            if (IDX >= pos && IDX1 < n) begin
              cell_op[g] = CELL_TAKE_RIGHT;
            end else if (IDX1 == n) begin
              cell_op[g] = CELL_CLEAR;
            end
          end
          REQ_REPLACE: begin
            if (hit1[g]) begin
              cell_op[g] = CELL_LOAD;
            end
          end
          REQ_SWAP: begin
            if (hit1[g]) begin
              cell_op[g]    = CELL_LOAD;
              cell_wdata[g] = rd2;
            end else if (hit2[g]) begin
              cell_op[g]    = CELL_LOAD;
              cell_wdata[g] = rd1;
            end
          end
          default: cell_op[g] = CELL_HOLD;
        endcase
      end
    end

    pil_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (cell_op[g]),
      .wdata_i(cell_wdata[g]),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept && dec.ok) begin
      if (dec.kind == REQ_INSERT) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else if (dec.kind == REQ_DELETE) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.status     <= dec.status;
      out_q.read_value <= (dec.ok && (dec.kind == REQ_READ || dec.kind == REQ_REPLACE)) ?
                          VAL_W'(rd1) : '0;
      out_q.count      <= CNT_OUT_W'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `PIL_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
  `PIL_ASSERT(a_cnt_idle, !accept |=> $stable(cnt_q), "count moved without a transaction")
  `PIL_ASSERT(a_result_after_accept, accept |=> out_valid_q, "no result after transaction")
  `PIL_ASSERT(a_full_status, out_valid_q && out_q.status == STATUS_FULL |-> is_full, "full with room")
  `PIL_ASSERT(a_tail_clear, !is_full |-> cell_data[CAPACITY-1] == '0, "unused tail cell not clear")

endmodule
